@@ rtl/sdx_pkg.sv @@
package sdx_pkg;

  // Number of digit fields in one result
  localparam int unsigned DigitFields = 3;

  // ASCII bounds of the letter ranges
  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5A;
  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] LowerZ = 8'h7A;
  localparam logic [6:0] LeadBase = 7'h41;

  // Letter codes
  localparam logic [2:0] CodeVowel = 3'd0;
  localparam logic [2:0] CodeLabial = 3'd1;
  localparam logic [2:0] CodeGuttural = 3'd2;
  localparam logic [2:0] CodeDental = 3'd3;
  localparam logic [2:0] CodeLateral = 3'd4;
  localparam logic [2:0] CodeNasal = 3'd5;
  localparam logic [2:0] CodeRhotic = 3'd6;

  // Classified character
  typedef struct packed {
    logic       is_letter;
    logic [4:0] index;
    logic [2:0] code;
  } letter_info_t;

  // One finished code
  typedef struct packed {
    logic [6:0] lead_letter;
    logic [2:0] digit_one;
    logic [2:0] digit_two;
    logic [2:0] digit_three;
    logic       no_letters;
  } result_t;

  // Map a letter index 0..25 to its code
  function automatic logic [2:0] letter_code(input logic [4:0] index);
    logic [2:0] code;
    case (index)
      5'd1, 5'd5, 5'd15, 5'd21: code = CodeLabial;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: code = CodeGuttural;
      5'd3, 5'd19: code = CodeDental;
      5'd11: code = CodeLateral;
      5'd12, 5'd13: code = CodeNasal;
      5'd17: code = CodeRhotic;
      default: code = CodeVowel;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/sdx_classify.sv @@
module sdx_classify (
  input  logic [7:0]            char_code,
  output sdx_pkg::letter_info_t info
);
  import sdx_pkg::*;

  logic [7:0] offset;

  // Fold case and find the letter index
  always_comb begin
    info = '0;
    offset = '0;
    if (char_code inside {[UpperA:UpperZ]}) begin
      info.is_letter = 1'b1;
      offset = char_code - UpperA;
    end else if (char_code inside {[LowerA:LowerZ]}) begin
      info.is_letter = 1'b1;
      offset = char_code - LowerA;
    end
    info.index = offset[4:0];
    info.code = letter_code(offset[4:0]);
  end

endmodule

@@ rtl/sdx_accum.sv @@
module sdx_accum #(
  parameter int unsigned DIGIT_LIMIT = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  last,
  input  sdx_pkg::letter_info_t info,
  output sdx_pkg::result_t      result
);
  import sdx_pkg::*;

  localparam logic [1:0] Limit = 2'(DIGIT_LIMIT);

  logic [4:0] lead_index, lead_index_next;
  logic       have_letter, have_letter_next;
  logic [2:0] previous_code, previous_code_next;
  logic [1:0] digit_count, digit_count_next;
  logic [2:0] digit_store [DigitFields];
  logic [2:0] digit_store_next [DigitFields];

  // Fold one character into the running code
  always_comb begin
    lead_index_next = lead_index;
    have_letter_next = have_letter;
    previous_code_next = previous_code;
    digit_count_next = digit_count;
    for (int i = 0; i < DigitFields; i++) begin
      digit_store_next[i] = digit_store[i];
    end
    if (step && info.is_letter) begin
      if (!have_letter) begin
        have_letter_next = 1'b1;
        lead_index_next = info.index;
      end else if (info.code != previous_code && info.code != CodeVowel &&
                   digit_count < Limit) begin
        for (int i = 0; i < DigitFields; i++) begin
          if (digit_count == 2'(i)) begin
            digit_store_next[i] = info.code;
          end
        end
        digit_count_next = digit_count + 2'd1;
      end
      previous_code_next = info.code;
    end
  end

  // Build the result from the updated state
  always_comb begin
    result = '0;
    if (have_letter_next) begin
      result.lead_letter = LeadBase + {2'b00, lead_index_next};
      result.digit_one = digit_store_next[0];
      result.digit_two = digit_store_next[1];
      result.digit_three = digit_store_next[2];
    end else begin
      result.no_letters = 1'b1;
    end
  end

  // Hold state, clear it after each name
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      lead_index <= '0;
      have_letter <= 1'b0;
      previous_code <= '0;
      digit_count <= '0;
      for (int i = 0; i < DigitFields; i++) begin
        digit_store[i] <= '0;
      end
    end else begin
      lead_index <= lead_index_next;
      have_letter <= have_letter_next;
      previous_code <= previous_code_next;
      digit_count <= digit_count_next;
      for (int i = 0; i < DigitFields; i++) begin
        digit_store[i] <= digit_store_next[i];
      end
    end
  end

endmodule

@@ rtl/soundex_phonetic_encoder.sv @@
// Soundex encoder, four-character form by default.
// Input channel: char_valid / char_ready carry one request per character,
// char_code (8-bit ASCII) and end_of_name marking the last character.
// Non-letters are skipped; case is ignored.
// Output channel: code_valid / code_ready carry one request per name:
// lead_letter, three zero-padded digits, and no_letters for a name
// with no letter in it (all other fields then zero).
// Throughput: one character per cycle, sustained, save for the stall below.
// Each accepted character waits in the character register and is folded
// into the state when it advances; the final one also loads the result.
// The character register feeds the state update and result register.
// Stall: a waiting result blocks only a following end-marked character;
// other characters keep flowing into the state.
// Reset (rst, synchronous): clears the state and drops any pending result.
module soundex_phonetic_encoder #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_code,
  input  logic       end_of_name,
  output logic       code_valid,
  input  logic       code_ready,
  output logic [6:0] lead_letter,
  output logic [2:0] digit_one,
  output logic [2:0] digit_two,
  output logic [2:0] digit_three,
  output logic       no_letters
);
  import sdx_pkg::*;

  localparam int unsigned DigitLimit =
    (CODE_LENGTH - 1 > DigitFields) ? DigitFields : CODE_LENGTH - 1;

  logic         s1_valid;
  logic [7:0]   s1_char;
  logic         s1_end;
  logic         advance;
  letter_info_t info;
  result_t      result_next;
  result_t      result;

  // Advance unless an end-marked character meets a stalled result
  assign advance = s1_valid && !(s1_end && code_valid && !code_ready);
  assign char_ready = !s1_valid || advance;

  // Hold the input request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      s1_char <= char_code;
      s1_end <= end_of_name;
    end
  end

  sdx_classify u_classify (
    .char_code(s1_char),
    .info     (info)
  );

  sdx_accum #(
    .DIGIT_LIMIT(DigitLimit)
  ) u_accum (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .last  (s1_end),
    .info  (info),
    .result(result_next)
  );

  // Load the result register on the end mark, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (advance && s1_end) begin
      code_valid <= 1'b1;
    end else if (code_ready) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_end) begin
      result <= result_next;
    end
  end

  assign lead_letter = result.lead_letter;
  assign digit_one = result.digit_one;
  assign digit_two = result.digit_two;
  assign digit_three = result.digit_three;
  assign no_letters = result.no_letters;

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    code_valid && no_letters |-> lead_letter == 7'd0 && digit_one == 3'd0 &&
      digit_two == 3'd0 && digit_three == 3'd0)
    else $error("no_letters result carries nonzero fields");

  a_lead_upper: assert property (@(posedge clk) disable iff (rst)
    code_valid && !no_letters |-> lead_letter >= 7'h41 && lead_letter <= 7'h5A)
    else $error("lead letter is not upper-case");

  a_digit_order: assert property (@(posedge clk) disable iff (rst)
    code_valid && (digit_three != 3'd0 || digit_two != 3'd0) |-> digit_one != 3'd0 &&
      (digit_three == 3'd0 || digit_two != 3'd0))
    else $error("digits not packed from the first field");

  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_end && code_valid && !code_ready |-> !char_ready)
    else $error("end mark accepted over a stalled result");
`endif

endmodule
